### design/obpr_pkg.sv
// Shared types and constants of the breadcrumb path recorder.
// Used by obpr_pose_mem, obpr_dist_unit and the top level; depends on nothing.
package obpr_pkg;

  localparam int unsigned PATH_DEPTH_DEF = 1024;

  localparam int unsigned POS_W   = 32;
  localparam int unsigned YAW_W   = 16;
  localparam int unsigned THR_W   = 16;
  localparam int unsigned MAG_W   = 21;   // capped difference magnitude, up to 2^20
  localparam int unsigned SQ_W    = 42;   // one squared magnitude
  localparam int unsigned DSQ_W   = 42;   // sum of three squares, below 2^42
  localparam int unsigned LEN_W   = 11;
  localparam int unsigned CFG_AW  = 3;

  localparam logic [MAG_W-1:0] DIFF_CAP = MAG_W'(1 << 20);

  // Input kinds
  localparam logic [1:0] KIND_ODOM  = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;

  // Modes
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_RECORD = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  // Register indexes
  localparam logic [CFG_AW-1:0] REG_MODE     = 3'd0;
  localparam logic [CFG_AW-1:0] REG_REC_DIST = 3'd1;
  localparam logic [CFG_AW-1:0] REG_REC_ANG  = 3'd2;
  localparam logic [CFG_AW-1:0] REG_CLR_DIST = 3'd3;
  localparam logic [CFG_AW-1:0] REG_CLR_ANG  = 3'd4;

  // Register reset values
  localparam logic [1:0]       MODE_RST     = MODE_RECORD;
  localparam logic [THR_W-1:0] REC_DIST_RST = 16'd50;
  localparam logic [THR_W-1:0] REC_ANG_RST  = 16'd1043;
  localparam logic [THR_W-1:0] CLR_DIST_RST = 16'd500;
  localparam logic [THR_W-1:0] CLR_ANG_RST  = 16'd1043;

  typedef struct packed {
    logic [YAW_W-1:0]        yaw;
    logic signed [POS_W-1:0] z;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] x;
  } pose_t;

  localparam int unsigned POSE_W = $bits(pose_t);

  typedef struct packed {
    logic  start;
    pose_t top;
    pose_t cur;
  } dist_req_t;

  typedef struct packed {
    logic             done;
    logic [DSQ_W-1:0] dsq;
    logic [YAW_W-1:0] yawd;
  } dist_res_t;

endpackage

### design/obpr_pose_mem.sv
// Pose store: one write port, one read port with registered read data.
// Depends on obpr_pkg for the pose type.
module obpr_pose_mem
  import obpr_pkg::*;
#(
  parameter int unsigned DEPTH = PATH_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  pose_t         wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output pose_t         rdata_o
);

  logic [POSE_W-1:0] mem [DEPTH];
  logic [POSE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = pose_t'(rdata_q);

endmodule

### design/obpr_dist_unit.sv
// Three-stage distance unit: capped coordinate differences and yaw difference,
// then squares, then their sum. Depends on obpr_pkg.
module obpr_dist_unit
  import obpr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  dist_req_t req_i,
  output dist_res_t res_o
);

  function automatic logic [MAG_W-1:0] cap_mag(input logic signed [POS_W-1:0] a,
                                              input logic signed [POS_W-1:0] b);
    logic signed [POS_W:0] d;
    logic [POS_W:0]        m;
    d = {a[POS_W-1], a} - {b[POS_W-1], b};
    m = d[POS_W] ? (POS_W+1)'(-d) : (POS_W+1)'(d);
    return (m > (POS_W+1)'(DIFF_CAP)) ? DIFF_CAP : m[MAG_W-1:0];
  endfunction

  logic [2:0]       vld_q;
  logic [MAG_W-1:0] mx_q, my_q, mz_q;
  logic [YAW_W-1:0] yawd1_q, yawd2_q, yawd3_q;
  logic [SQ_W-1:0]  sx_q, sy_q, sz_q;
  logic [DSQ_W-1:0] dsq_q;
  logic [YAW_W-1:0] yraw;

  // wrapped yaw difference, then its magnitude
  assign yraw = req_i.cur.yaw - req_i.top.yaw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], req_i.start};
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q    <= cap_mag(req_i.top.x, req_i.cur.x);
    my_q    <= cap_mag(req_i.top.y, req_i.cur.y);
    mz_q    <= cap_mag(req_i.top.z, req_i.cur.z);
    yawd1_q <= yraw[YAW_W-1] ? YAW_W'(~yraw + 1'b1) : yraw;
    sx_q    <= mx_q * mx_q;
    sy_q    <= my_q * my_q;
    sz_q    <= mz_q * mz_q;
    yawd2_q <= yawd1_q;
    dsq_q   <= sx_q + sy_q + sz_q;
    yawd3_q <= yawd2_q;
  end

  assign res_o.done = vld_q[2];
  assign res_o.dsq  = dsq_q;
  assign res_o.yawd = yawd3_q;

endmodule

### design/odometry_breadcrumb_path_recorder.sv
// Breadcrumb path recorder: a stack of poses in a one-port-read, one-port-write
// memory, driven by a small sequencer around a three-stage distance unit. One
// input word gives one result word. Clear-path, set-start, idle-mode and unused
// kinds go straight to the output load and result register, as do a clear sample
// with one pose or none and a record sample on an empty path; other record samples
// pass memory read, three distance stages, output load and result register; a
// clear sample on a longer path repeats read and distance stages for each check,
// as every check rereads the new top pose from memory. A new word is accepted
// while the previous result still waits on the output. No clearing pass is needed
// after reset: only entries below the pose count are read.
module odometry_breadcrumb_path_recorder
  import obpr_pkg::*;
#(
  parameter int unsigned PATH_DEPTH = PATH_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [CFG_AW-1:0]   cfg_addr_i,
  input  logic [THR_W-1:0]    cfg_wdata_i,
  // input stream
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [111:0]        s_axis_tdata_i,   // pos_x, pos_y, pos_z, heading
  input  logic [1:0]          s_axis_tuser_i,   // kind
  // result stream
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [15:0]         m_axis_tdata_o    // accepted, clearing_error,
                                                // store_full, path_length, pad
);

  localparam int unsigned CW = $clog2(PATH_DEPTH + 1);
  localparam int unsigned AW = $clog2(PATH_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_DIST  = 4'b0100,
    S_OUT   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [1:0]       mode_q;
  logic [THR_W-1:0] rec_dist_q, rec_ang_q, clr_dist_q, clr_ang_q;

  logic [CW-1:0]    count_q, count_d;
  pose_t            cur_q, cur_d;
  logic [31:0]      rd_sq_q, rd_sq_d, cd_sq_q, cd_sq_d;
  logic             acc_q, acc_d, err_q, err_d, full_q, full_d;
  logic             out_valid_q, out_valid_d;
  logic [15:0]      out_data_q, out_data_d;

  pose_t            in_pose;
  logic             in_fire;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  pose_t            mem_wdata, mem_rdata;
  dist_req_t        dreq;
  dist_res_t        dres;
  logic [CW-1:0]    cnt_m1, cnt_m2;
  logic             push, ok;
  logic [DSQ_W-1:0] lim2;
  logic [CW+LEN_W-1:0] len_ext;

  assign in_pose = pose_t'(s_axis_tdata_i);
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire = s_axis_tvalid_i & s_axis_tready_o;

  assign cnt_m1 = count_q - CW'(1);
  assign cnt_m2 = count_q - CW'(2);
  assign lim2   = DSQ_W'(cd_sq_q) << 2;
  assign push   = (dres.dsq > DSQ_W'(rd_sq_q)) || (dres.yawd > rec_ang_q);
  assign ok     = (dres.dsq < DSQ_W'(cd_sq_q)) && (dres.yawd < clr_ang_q);
  assign len_ext = {{LEN_W{1'b0}}, count_q};

  assign dreq.start = (state_q == S_FETCH);
  assign dreq.top   = mem_rdata;
  assign dreq.cur   = cur_q;

  obpr_pose_mem #(
    .DEPTH (PATH_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  obpr_dist_unit u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .res_o  (dres)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    cur_d       = cur_q;
    rd_sq_d     = rd_sq_q;
    cd_sq_d     = cd_sq_q;
    acc_d       = acc_q;
    err_d       = err_q;
    full_d      = full_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    mem_we      = 1'b0;
    mem_waddr   = count_q[AW-1:0];
    mem_wdata   = cur_q;
    mem_re      = 1'b0;
    mem_raddr   = cnt_m1[AW-1:0];

    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cur_d   = in_pose;
          rd_sq_d = rec_dist_q * rec_dist_q;
          cd_sq_d = clr_dist_q * clr_dist_q;
          acc_d   = 1'b0;
          err_d   = 1'b0;
          full_d  = 1'b0;
          state_d = S_OUT;
          mem_wdata = in_pose;
          case (s_axis_tuser_i)
            KIND_ODOM: begin
              if (mode_q == MODE_RECORD) begin
                if (count_q == '0) begin
                  mem_we    = 1'b1;
                  mem_waddr = '0;
                  count_d   = CW'(1);
                  acc_d     = 1'b1;
                end else begin
                  mem_re  = 1'b1;
                  state_d = S_FETCH;
                end
              end else if (mode_q == MODE_CLEAR) begin
                if (count_q > CW'(1)) begin
                  mem_re  = 1'b1;
                  state_d = S_FETCH;
                end
              end
            end
            KIND_CLEAR: begin
              count_d = '0;
            end
            KIND_START: begin
              mem_we    = 1'b1;
              mem_waddr = '0;
              if (count_q == '0) begin
                count_d = CW'(1);
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_FETCH: begin
        state_d = S_DIST;
      end
      S_DIST: begin
        if (dres.done) begin
          state_d = S_OUT;
          if (mode_q == MODE_RECORD) begin
            if (push) begin
              if (count_q >= CW'(PATH_DEPTH)) begin
                full_d = 1'b1;
              end else begin
                mem_we  = 1'b1;
                count_d = count_q + CW'(1);
                acc_d   = 1'b1;
              end
            end
          end else begin
            err_d = (dres.dsq > lim2);
            if (ok) begin
              count_d = cnt_m1;
              acc_d   = 1'b1;
              // pop and check the new top while more than one pose is left
              if (count_q > CW'(2)) begin
                mem_re    = 1'b1;
                mem_raddr = cnt_m2[AW-1:0];
                state_d   = S_FETCH;
              end
            end
          end
        end
      end
      S_OUT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = {2'b00, len_ext[LEN_W-1:0], full_q, err_q, acc_q};
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      mode_q      <= MODE_RST;
      rec_dist_q  <= REC_DIST_RST;
      rec_ang_q   <= REC_ANG_RST;
      clr_dist_q  <= CLR_DIST_RST;
      clr_ang_q   <= CLR_ANG_RST;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_MODE:     mode_q     <= cfg_wdata_i[1:0];
          REG_REC_DIST: rec_dist_q <= cfg_wdata_i;
          REG_REC_ANG:  rec_ang_q  <= cfg_wdata_i;
          REG_CLR_DIST: clr_dist_q <= cfg_wdata_i;
          REG_CLR_ANG:  clr_ang_q  <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    rd_sq_q    <= rd_sq_d;
    cd_sq_q    <= cd_sq_d;
    acc_q      <= acc_d;
    err_q      <= err_d;
    full_q     <= full_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
